// ----- rtl/core/weighted_relative_l1_distance_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Weighted relative L1 distance unit: assertion macros
// Concurrent assertion wrappers on clk_i with reset rst_ni; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RELATIVE_L1_DISTANCE_UNIT_DEFINES_SVH
`define WEIGHTED_RELATIVE_L1_DISTANCE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define WRL1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WRL1_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define WRL1_ASSERT(lbl, prop, msg)
`define WRL1_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ----- rtl/core/wrl1_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted relative L1 distance unit: package
// Shared widths, defaults, sequencer states and divider status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrl1_pkg;

  localparam int unsigned MaxElementsDef = 65536;
  localparam int unsigned FracBitsDef    = 16;

  localparam int unsigned ValW     = 17;
  localparam int unsigned WgtW     = 16;
  localparam int unsigned ProdW    = 2 * WgtW;
  localparam int unsigned MulAW    = ProdW;
  localparam int unsigned MulBW    = ValW;
  localparam int unsigned MulPW    = MulAW + MulBW;
  localparam int unsigned AccW     = 64;
  localparam int unsigned ResW     = 32;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 2 * ResW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_W,
    ST_MUL_N,
    ST_MUL_D,
    ST_ACC_D,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } wrl1_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } wrl1_div_stat_t;

endpackage

// ----- rtl/core/wrl1_mult.sv -----
// ----------------------------------------------------------------------------
// Weighted relative L1 distance unit: shared multiplier
// One registered unsigned multiplier used for every product of an element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrl1_mult (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [wrl1_pkg::MulAW-1:0] a_i,
  input  logic [wrl1_pkg::MulBW-1:0] b_i,
  output logic [wrl1_pkg::MulPW-1:0] p_o
);

  logic [wrl1_pkg::MulPW-1:0] p_q;
  logic [wrl1_pkg::MulPW-1:0] p_d;

  assign p_d = wrl1_pkg::MulPW'(a_i) * wrl1_pkg::MulPW'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/core/wrl1_div.sv -----
// ----------------------------------------------------------------------------
// Weighted relative L1 distance unit: ratio divider
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrl1_div #(
  parameter int unsigned FRAC_BITS = wrl1_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wrl1_pkg::AccW-1:0]    num_i,
  input  logic [wrl1_pkg::AccW-1:0]    den_i,
  output logic [wrl1_pkg::ResW-1:0]    quot_o,
  output wrl1_pkg::wrl1_div_stat_t     stat_o
);

  localparam int unsigned Steps = wrl1_pkg::AccW + FRAC_BITS;
  localparam int unsigned CntW  = $clog2(Steps);

  logic                        active_q;
  logic                        done_q;
  logic [CntW-1:0]             cnt_q;
  logic [wrl1_pkg::AccW-1:0]   rem_q, rem_d;
  logic [wrl1_pkg::AccW-1:0]   dvd_q;
  logic [wrl1_pkg::AccW-1:0]   den_q;
  logic [wrl1_pkg::ResW-1:0]   quo_q;
  logic                        ovf_q;
  logic [wrl1_pkg::AccW:0]     shifted;
  logic [wrl1_pkg::AccW:0]     diff;
  logic                        ge;

  assign shifted = {rem_q, dvd_q[wrl1_pkg::AccW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};
  assign rem_d   = ge ? diff[wrl1_pkg::AccW-1:0] : shifted[wrl1_pkg::AccW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (active_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[wrl1_pkg::AccW-2:0], 1'b0};
      quo_q <= {quo_q[wrl1_pkg::ResW-2:0], ge};
      ovf_q <= ovf_q | quo_q[wrl1_pkg::ResW-1];
    end
  end

  assign quot_o      = ovf_q ? '1 : quo_q;
  assign stat_o.busy = active_q;
  assign stat_o.done = done_q;

endmodule

// ----- rtl/core/weighted_relative_l1_distance_unit.sv -----
// ----------------------------------------------------------------------------
// Weighted relative L1 distance unit: top level
// Per element: three products through one shared multiplier.
// End of reference: a check state, then the bit-per-cycle divider, then
// an emit state; the divider is bypassed when the term is skipped.
// Asynchronous active-low reset clears accumulators, total and threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weighted_relative_l1_distance_unit_defines.svh"

module weighted_relative_l1_distance_unit #(
  parameter int unsigned MAX_ELEMENTS = wrl1_pkg::MaxElementsDef,
  parameter int unsigned FRAC_BITS    = wrl1_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wrl1_pkg::CfgW-1:0]     cfg_data_i,     // min_denominator
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cand_value[16:0], ref_value[33:17], row_weight[49:34], col_weight[65:50]
  input  logic [wrl1_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,   // end_of_reference
  input  logic                          s_axis_tuser,   // end_of_call
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [wrl1_pkg::OutDataW-1:0] m_axis_tdata,   // term[31:0], total[63:32]
  output logic                          m_axis_tlast,   // call_done
  output logic                          m_axis_tuser    // term_skipped
);

  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned VW   = wrl1_pkg::ValW;
  localparam int unsigned WW   = wrl1_pkg::WgtW;
  localparam int unsigned AW   = wrl1_pkg::AccW;
  localparam int unsigned RW   = wrl1_pkg::ResW;

  wrl1_pkg::wrl1_state_e     state_q, state_d;
  wrl1_pkg::wrl1_div_stat_t  div_stat;

  logic [wrl1_pkg::CfgW-1:0]  min_den_q;
  logic [VW-1:0]              cand_q, ref_q;
  logic [WW-1:0]              rw_q, cw_q;
  logic                       eor_q, eoc_q;
  logic [wrl1_pkg::ProdW-1:0] w_q;
  logic [AW-1:0]              num_acc_q, den_acc_q;
  logic [CntW-1:0]            elem_cnt_q;
  logic [RW-1:0]              total_q;
  logic                       skip_q;

  logic                       out_valid_q;
  logic [RW-1:0]              out_term_q, out_total_q;
  logic                       out_skip_q, out_done_q;

  logic                       in_fire;
  logic                       room;
  logic                       emit_fire;
  logic                       below_max;
  logic [VW-1:0]              diff;
  logic [wrl1_pkg::MulAW-1:0] mul_a;
  logic [wrl1_pkg::MulBW-1:0] mul_b;
  logic [wrl1_pkg::MulPW-1:0] prod;
  logic                       div_start;
  logic [RW-1:0]              div_quot;
  logic [AW:0]                num_sum, den_sum;
  logic [RW-1:0]              term;
  logic [RW:0]                tot_sum;
  logic [RW-1:0]              tot_new;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign room        = !out_valid_q || m_axis_tready;
  assign emit_fire   = (state_q == wrl1_pkg::ST_EMIT) && room;
  assign below_max   = elem_cnt_q < CntW'(MAX_ELEMENTS);
  assign diff        = (cand_q >= ref_q) ? (cand_q - ref_q) : (ref_q - cand_q);

  wrl1_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .p_o    (prod)
  );

  wrl1_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_acc_q),
    .den_i   (den_acc_q),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wrl1_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (below_max) begin
            state_d = wrl1_pkg::ST_MUL_W;
          end else if (s_axis_tlast) begin
            state_d = wrl1_pkg::ST_CHECK;
          end
        end
      end
      wrl1_pkg::ST_MUL_W: state_d = wrl1_pkg::ST_MUL_N;
      wrl1_pkg::ST_MUL_N: state_d = wrl1_pkg::ST_MUL_D;
      wrl1_pkg::ST_MUL_D: state_d = wrl1_pkg::ST_ACC_D;
      wrl1_pkg::ST_ACC_D: state_d = eor_q ? wrl1_pkg::ST_CHECK : wrl1_pkg::ST_IDLE;
      wrl1_pkg::ST_CHECK: begin
        state_d = (den_acc_q <= AW'(min_den_q)) ? wrl1_pkg::ST_EMIT : wrl1_pkg::ST_DIV;
      end
      wrl1_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = wrl1_pkg::ST_EMIT;
        end
      end
      wrl1_pkg::ST_EMIT: begin
        if (room) begin
          state_d = wrl1_pkg::ST_IDLE;
        end
      end
      default: state_d = wrl1_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    mul_a         = w_q;
    mul_b         = ref_q;
    unique case (state_q)
      wrl1_pkg::ST_IDLE: s_axis_tready = 1'b1;
      wrl1_pkg::ST_MUL_W: begin
        mul_a = wrl1_pkg::MulAW'(rw_q);
        mul_b = wrl1_pkg::MulBW'(cw_q);
      end
      wrl1_pkg::ST_MUL_N: begin
        mul_a = prod[wrl1_pkg::ProdW-1:0];
        mul_b = diff;
      end
      wrl1_pkg::ST_CHECK: div_start = !(den_acc_q <= AW'(min_den_q));
      default: ;
    endcase
  end

  assign num_sum = {1'b0, num_acc_q} + (AW + 1)'(prod);
  assign den_sum = {1'b0, den_acc_q} + (AW + 1)'(prod);
  assign term    = skip_q ? '0 : div_quot;
  assign tot_sum = {1'b0, total_q} + {1'b0, term};
  assign tot_new = tot_sum[RW] ? '1 : tot_sum[RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrl1_pkg::ST_IDLE;
      min_den_q   <= '0;
      num_acc_q   <= '0;
      den_acc_q   <= '0;
      elem_cnt_q  <= '0;
      total_q     <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        min_den_q <= cfg_data_i;
      end
      if (state_q == wrl1_pkg::ST_MUL_D) begin
        num_acc_q <= num_sum[AW] ? '1 : num_sum[AW-1:0];
      end
      if (state_q == wrl1_pkg::ST_ACC_D) begin
        den_acc_q  <= den_sum[AW] ? '1 : den_sum[AW-1:0];
        elem_cnt_q <= elem_cnt_q + 1'b1;
      end
      if (state_q == wrl1_pkg::ST_CHECK) begin
        skip_q <= den_acc_q <= AW'(min_den_q);
      end
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
        num_acc_q   <= '0;
        den_acc_q   <= '0;
        elem_cnt_q  <= '0;
        total_q     <= eoc_q ? '0 : tot_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cand_q <= s_axis_tdata[VW-1:0];
      ref_q  <= s_axis_tdata[2*VW-1:VW];
      rw_q   <= s_axis_tdata[2*VW+WW-1:2*VW];
      cw_q   <= s_axis_tdata[2*VW+2*WW-1:2*VW+WW];
      eor_q  <= s_axis_tlast;
      eoc_q  <= s_axis_tuser;
    end
    if (state_q == wrl1_pkg::ST_MUL_N) begin
      w_q <= prod[wrl1_pkg::ProdW-1:0];
    end
    if (emit_fire) begin
      out_term_q  <= term;
      out_total_q <= tot_new;
      out_skip_q  <= skip_q;
      out_done_q  <= eoc_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_total_q, out_term_q};
  assign m_axis_tlast  = out_done_q;
  assign m_axis_tuser  = out_skip_q;

  `WRL1_ASSERT(a_skip_term_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[RW-1:0] == '0), "skipped term not zero")
  `WRL1_ASSERT(a_acc_clear, emit_fire |=> (num_acc_q == '0 && den_acc_q == '0 && elem_cnt_q == '0), "accumulators not cleared after result")
  `WRL1_ASSERT(a_div_done_state, div_stat.done |-> (state_q == wrl1_pkg::ST_DIV), "divider finished outside divide phase")
  `WRL1_ASSERT_NEVER(a_no_accept_busy, in_fire && div_stat.busy, "input accepted while divider busy")

endmodule

// ----- verif/weighted_relative_l1_distance_unit_test.sv -----
// ----------------------------------------------------------------------------
// Weighted relative L1 distance unit: self-checking testbench
// Streams element pairs with row and column weights and checks every term
// against a listed result or an in-bench fixed-point predictor. A table of
// directed cases comes first: empty and saturating ratios, threshold edges,
// stray end-of-call marks and out-of-range values. Random references under
// four threshold settings follow. Both sides insert random gaps, and at one
// point the sink holds off long enough to back the unit up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_relative_l1_distance_unit_test;

  localparam int unsigned SETTLE_CYCLES   = 120;
  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned SHOWN_ERRORS    = 10;

  typedef enum logic {ROW_ELEM, ROW_THRESH} row_kind_e;

  typedef struct packed {
    logic [wrl1_pkg::ValW-1:0] cand;
    logic [wrl1_pkg::ValW-1:0] refv;
    logic [wrl1_pkg::WgtW-1:0] row_w;
    logic [wrl1_pkg::WgtW-1:0] col_w;
    logic                      eor;
    logic                      eoc;
  } elem_t;

  typedef struct packed {
    logic [wrl1_pkg::ResW-1:0] term;
    logic                      skipped;
    logic [wrl1_pkg::ResW-1:0] total;
    logic                      done;
  } dist_res_t;

  typedef struct packed {
    logic      has;
    dist_res_t res;
  } term_hint_t;

  typedef struct packed {
    row_kind_e                 kind;
    logic [wrl1_pkg::CfgW-1:0] thresh;
    elem_t                     elem;
    logic                      has_want;
    dist_res_t                 want;
  } dir_row_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [wrl1_pkg::CfgW-1:0]     cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [wrl1_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          s_axis_tuser  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [wrl1_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          m_axis_tuser;

  // predictor state
  logic [wrl1_pkg::CfgW-1:0] min_den    = '0;
  logic [wrl1_pkg::AccW-1:0] num_sum    = '0;
  logic [wrl1_pkg::AccW-1:0] den_sum    = '0;
  logic [wrl1_pkg::ResW-1:0] call_total = '0;
  int unsigned               elem_cnt   = 0;

  dist_res_t   term_q [$];
  term_hint_t  hint_q [$];
  dir_row_t    directed_rows [20];
  int unsigned err_cnt     = 0;
  int unsigned idle_cycles = 0;
  int unsigned sink_gap    = 0;
  bit          gaps_on     = 1'b1;
  bit          sink_hold   = 1'b0;
  bit          pressure_go = 1'b0;

  weighted_relative_l1_distance_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [wrl1_pkg::ValW-1:0] rand_value();
    case ($urandom_range(0, 19))
      0: return 17'h00000;
      1: return 17'h10000;
      2: return 17'h1FFFF;
      3: return 17'($urandom_range(32'h10001, 32'h1FFFF));
      default: return 17'($urandom_range(0, 32'h10000));
    endcase
  endfunction

  function automatic logic [wrl1_pkg::WgtW-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit count_error();
    err_cnt++;
    return err_cnt <= SHOWN_ERRORS;
  endfunction

  // Accumulate one element; on end of reference form the term and advance the total.
  function automatic bit accumulate_element(input elem_t e, output dist_res_t r);
    logic [wrl1_pkg::ProdW-1:0] w;
    logic [wrl1_pkg::ValW-1:0]  diff;
    logic [wrl1_pkg::AccW:0]    nsum;
    logic [wrl1_pkg::AccW:0]    dsum;
    logic [95:0]                quot;
    logic [wrl1_pkg::ResW:0]    tsum;
    r = '0;
    if (elem_cnt < wrl1_pkg::MaxElementsDef) begin
      w    = e.row_w * e.col_w;
      diff = (e.cand >= e.refv) ? e.cand - e.refv : e.refv - e.cand;
      nsum = {1'b0, num_sum} + w * diff;
      dsum = {1'b0, den_sum} + w * e.refv;
      num_sum = nsum[wrl1_pkg::AccW] ? '1 : nsum[wrl1_pkg::AccW-1:0];
      den_sum = dsum[wrl1_pkg::AccW] ? '1 : dsum[wrl1_pkg::AccW-1:0];
      elem_cnt++;
    end
    if (!e.eor) return 1'b0;
    r.skipped = !(den_sum > {32'b0, min_den});
    if (!r.skipped) begin
      quot   = ({32'b0, num_sum} << wrl1_pkg::FracBitsDef) / {32'b0, den_sum};
      r.term = (quot > 96'hFFFF_FFFF) ? '1 : quot[wrl1_pkg::ResW-1:0];
    end
    tsum       = {1'b0, call_total} + r.term;
    call_total = tsum[wrl1_pkg::ResW] ? '1 : tsum[wrl1_pkg::ResW-1:0];
    r.total    = call_total;
    r.done     = e.eoc;
    num_sum    = '0;
    den_sum    = '0;
    elem_cnt   = 0;
    if (e.eoc) call_total = '0;
    return 1'b1;
  endfunction

  task automatic push_elem(input elem_t e, input logic has_want, input dist_res_t want);
    int unsigned gap;
    term_hint_t  h;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    h.has = has_want;
    h.res = want;
    hint_q.insert(hint_q.size(), h);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, e.col_w, e.row_w, e.refv, e.cand};
    s_axis_tlast  <= e.eor;
    s_axis_tuser  <= e.eoc;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (term_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [wrl1_pkg::CfgW-1:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sink side: random gaps plus one long hold-off
  always @(posedge clk_i) begin
    if (sink_gap != 0) begin
      sink_gap      <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (gaps_on && $urandom_range(0, 3) == 0) sink_gap <= pick_gap();
    end
  end

  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : watch
    elem_t      e;
    dist_res_t  pred;
    dist_res_t  got;
    dist_res_t  want;
    term_hint_t h;
    logic       produced;
    logic       fired;
    if (rst_ni) begin
      fired = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        min_den = cfg_data_i;
        fired   = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fired   = 1'b1;
        e.cand  = s_axis_tdata[16:0];
        e.refv  = s_axis_tdata[33:17];
        e.row_w = s_axis_tdata[49:34];
        e.col_w = s_axis_tdata[65:50];
        e.eor   = s_axis_tlast;
        e.eoc   = s_axis_tuser;
        h = '0;
        if (hint_q.size() != 0) h = hint_q.pop_front();
        produced = accumulate_element(e, pred);
        if (h.has) term_q.insert(term_q.size(), h.res);
        else if (produced) term_q.insert(term_q.size(), pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        fired       = 1'b1;
        got.term    = m_axis_tdata[31:0];
        got.total   = m_axis_tdata[63:32];
        got.skipped = m_axis_tuser;
        got.done    = m_axis_tlast;
        if (term_q.size() == 0) begin
          if (count_error())
            $display("unexpected transfer: term=%h skip=%b total=%h done=%b",
                     got.term, got.skipped, got.total, got.done);
        end else begin
          want = term_q.pop_front();
          if (got.term !== want.term || got.skipped !== want.skipped ||
              got.total !== want.total || got.done !== want.done) begin
            if (count_error())
              $display("mismatch: want term=%h skip=%b total=%h done=%b, got %h %b %h %b",
                       want.term, want.skipped, want.total, want.done,
                       got.term, got.skipped, got.total, got.done);
          end
        end
      end
      idle_cycles = fired ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("weighted_relative_l1_distance_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    elem_t                     e;
    logic [wrl1_pkg::CfgW-1:0] thr;
    int unsigned               phase;
    int unsigned               sent;
    int unsigned               len;
    int unsigned               k;

    directed_rows[0]  = '{ROW_ELEM, 32'h0,
                          '{17'h00000, 17'h00000, 16'h0100, 16'h0100, 1'b1, 1'b0},
                          1'b1, '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0}};
    directed_rows[1]  = '{ROW_ELEM, 32'h0,
                          '{17'h10000, 17'h10000, 16'h0100, 16'h0100, 1'b1, 1'b0},
                          1'b1, '{32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0}};
    directed_rows[2]  = '{ROW_ELEM, 32'h0,
                          '{17'h00000, 17'h10000, 16'h0100, 16'h0100, 1'b1, 1'b0},
                          1'b1, '{32'h0001_0000, 1'b0, 32'h0001_0000, 1'b0}};
    directed_rows[3]  = '{ROW_ELEM, 32'h0,
                          '{17'h10000, 17'h00001, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1},
                          1'b1, '{32'hFFFF_0000, 1'b0, 32'hFFFF_FFFF, 1'b1}};
    directed_rows[4]  = '{ROW_ELEM, 32'h0,
                          '{17'h1FFFF, 17'h00001, 16'h0100, 16'h0100, 1'b1, 1'b0},
                          1'b1, '{32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0}};
    directed_rows[5]  = '{ROW_ELEM, 32'h0,
                          '{17'h00000, 17'h1FFFF, 16'h0100, 16'h0100, 1'b1, 1'b1},
                          1'b1, '{32'h0001_0000, 1'b0, 32'hFFFF_FFFF, 1'b1}};
    directed_rows[6]  = '{ROW_ELEM, 32'h0,
                          '{17'h003E8, 17'h00BB8, 16'h0180, 16'h00C0, 1'b0, 1'b1},
                          1'b0, '0};
    directed_rows[7]  = '{ROW_ELEM, 32'h0,
                          '{17'h01388, 17'h009C4, 16'h0040, 16'h1234, 1'b0, 1'b0},
                          1'b0, '0};
    directed_rows[8]  = '{ROW_ELEM, 32'h0,
                          '{17'h00000, 17'h08000, 16'h0000, 16'hFFFF, 1'b0, 1'b0},
                          1'b0, '0};
    directed_rows[9]  = '{ROW_ELEM, 32'h0,
                          '{17'h00ABC, 17'h00DEF, 16'hA5A5, 16'h5A5A, 1'b1, 1'b0},
                          1'b0, '0};
    directed_rows[10] = '{ROW_ELEM, 32'h0,
                          '{17'h1FFFF, 17'h1FFFF, 16'h0000, 16'h0000, 1'b1, 1'b1},
                          1'b0, '0};
    directed_rows[11] = '{ROW_THRESH, 32'hFFFF_0000, '0, 1'b0, '0};
    directed_rows[12] = '{ROW_ELEM, 32'h0,
                          '{17'h00000, 17'h0FFFF, 16'h0100, 16'h0100, 1'b1, 1'b0},
                          1'b1, '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0}};
    directed_rows[13] = '{ROW_ELEM, 32'h0,
                          '{17'h00000, 17'h10000, 16'h0100, 16'h0100, 1'b1, 1'b1},
                          1'b1, '{32'h0001_0000, 1'b0, 32'h0001_0000, 1'b1}};
    directed_rows[14] = '{ROW_THRESH, 32'hFFFF_FFFF, '0, 1'b0, '0};
    directed_rows[15] = '{ROW_ELEM, 32'h0,
                          '{17'h00000, 17'h10000, 16'h0100, 16'h0100, 1'b1, 1'b0},
                          1'b1, '{32'h0001_0000, 1'b0, 32'h0001_0000, 1'b0}};
    directed_rows[16] = '{ROW_ELEM, 32'h0,
                          '{17'h08000, 17'h08000, 16'hFFFF, 16'h0001, 1'b1, 1'b1},
                          1'b1, '{32'h0000_0000, 1'b1, 32'h0001_0000, 1'b1}};
    directed_rows[17] = '{ROW_THRESH, 32'h0000_0000, '0, 1'b0, '0};
    directed_rows[18] = '{ROW_ELEM, 32'h0,
                          '{17'h1FFFF, 17'h00001, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0},
                          1'b0, '0};
    directed_rows[19] = '{ROW_ELEM, 32'h0,
                          '{17'h00000, 17'h10000, 16'h8001, 16'h7FFE, 1'b1, 1'b0},
                          1'b0, '0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_THRESH) begin
        write_threshold(directed_rows[i].thresh);
      end else begin
        push_elem(directed_rows[i].elem, directed_rows[i].has_want, directed_rows[i].want);
      end
    end

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: thr = $urandom_range(0, 32'h00FF_FFFF);
        1: thr = $urandom;
        2: thr = 32'hFFFF_FFFF;
        default: thr = 32'h0000_0000;
      endcase
      write_threshold(thr);
      if (phase == 1) pressure_go <= 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
        gaps_on <= ($urandom_range(0, 4) != 0);
        for (k = 0; k < len; k++) begin
          e.cand  = rand_value();
          e.refv  = rand_value();
          if ($urandom_range(0, 9) == 0) e.cand = e.refv;
          e.row_w = rand_weight();
          e.col_w = rand_weight();
          e.eor   = (k == len - 1);
          e.eoc   = e.eor ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 15) == 0);
          push_elem(e, 1'b0, '0);
        end
        sent += len;
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("weighted_relative_l1_distance_unit regression: pass");
    end else begin
      $display("weighted_relative_l1_distance_unit regression: fail");
    end
    $finish;
  end

endmodule
